// ===== design/dls_pkg.sv =====
// Package for the DDA line stepper.
// Holds widths, codes, the divider state type and the divider result word.
// No dependencies.
`default_nettype none

package dls_pkg;

  // Field and datapath widths
  localparam int unsigned COORD_BITS   = 12;
  localparam int unsigned FRAC_BITS    = 16;
  localparam int unsigned POS_BITS     = COORD_BITS + FRAC_BITS + 1;
  localparam int unsigned STEP_BITS    = FRAC_BITS + 2;
  localparam int unsigned OUT_BITS     = COORD_BITS + 1;
  localparam int unsigned DLT_BITS     = COORD_BITS + 1;
  localparam int unsigned QUO_BITS     = FRAC_BITS + 1;
  localparam int unsigned CNT_BITS     = $clog2(QUO_BITS);
  localparam int unsigned CFG_IDX_BITS = 1;

  // Configuration register indexes
  typedef enum logic [CFG_IDX_BITS-1:0] {
    CFG_OFFSET_X = 1'b0,
    CFG_OFFSET_Y = 1'b1
  } cfg_idx_e;

  // Input word actions
  typedef enum logic {
    ACT_LOAD = 1'b0,
    ACT_STEP = 1'b1
  } action_e;

  // Bit-serial divider states
  typedef enum logic [1:0] {
    DIV_IDLE,
    DIV_PREP,
    DIV_ITER
  } div_state_e;

  // Divider result handed to the stepper
  typedef struct packed {
    logic                done;
    logic                nonzero;
    logic                neg_x;
    logic                neg_y;
    logic [QUO_BITS-1:0] quo_x;
    logic [QUO_BITS-1:0] quo_y;
  } div_res_t;

endpackage

`default_nettype wire

// ===== design/dls_if.sv =====
// Channel interfaces of the DDA line stepper: input word and pixel word.
// Depends on dls_pkg.
`default_nettype none

interface dls_in_if;
  import dls_pkg::*;

  logic                         valid;
  logic                         ready;
  logic                         action;
  logic signed [COORD_BITS-1:0] start_x;
  logic signed [COORD_BITS-1:0] start_y;
  logic signed [COORD_BITS-1:0] end_x;
  logic signed [COORD_BITS-1:0] end_y;

  modport source (
    output valid, action, start_x, start_y, end_x, end_y,
    input  ready
  );

  modport sink (
    input  valid, action, start_x, start_y, end_x, end_y,
    output ready
  );
endinterface

interface dls_out_if;
  import dls_pkg::*;

  logic                       valid;
  logic                       ready;
  logic signed [OUT_BITS-1:0] pixel_x;
  logic signed [OUT_BITS-1:0] pixel_y;
  logic                       pixel_valid;
  logic                       last;

  modport source (
    output valid, pixel_x, pixel_y, pixel_valid, last,
    input  ready
  );

  modport sink (
    input  valid, pixel_x, pixel_y, pixel_valid, last,
    output ready
  );
endinterface

`default_nettype wire

// ===== design/dls_divider.sv =====
// Bit-serial restoring divider for the line step: |d| * 2^FRAC_BITS / max(|dx|,|dy|).
// Two lanes (x and y) share the divisor and produce one quotient bit each per cycle.
// Depends on dls_pkg.
`default_nettype none

module dls_divider (
  input  wire logic                                clk_i,
  input  wire logic                                rst_ni,
  input  wire logic                                start_i,
  input  wire logic signed [dls_pkg::DLT_BITS-1:0] dx_i,
  input  wire logic signed [dls_pkg::DLT_BITS-1:0] dy_i,
  output      logic                                busy_o,
  output      dls_pkg::div_res_t                   res_o
);
  import dls_pkg::*;

  div_state_e           state_q, state_d;
  logic [CNT_BITS-1:0]  cnt_q, cnt_d;
  logic                 done_q, done_d;

  logic [DLT_BITS-1:0]   dx_q, dy_q;
  logic [COORD_BITS-1:0] len_q;
  logic [COORD_BITS:0]   rem_x_q, rem_y_q;
  logic [QUO_BITS-1:0]   quo_x_q, quo_y_q;
  logic                  neg_x_q, neg_y_q, nonzero_q;

  logic [COORD_BITS-1:0] mag_x, mag_y, len;
  logic                  ge_x, ge_y;
  logic [COORD_BITS:0]   sub_x, sub_y;

  // Magnitudes and the major-axis length
  assign mag_x = dx_q[DLT_BITS-1] ? COORD_BITS'(-dx_q) : dx_q[COORD_BITS-1:0];
  assign mag_y = dy_q[DLT_BITS-1] ? COORD_BITS'(-dy_q) : dy_q[COORD_BITS-1:0];
  assign len   = (mag_x > mag_y) ? mag_x : mag_y;

  // One restoring step per lane: compare, subtract
  assign ge_x  = rem_x_q >= {1'b0, len_q};
  assign ge_y  = rem_y_q >= {1'b0, len_q};
  assign sub_x = rem_x_q - (ge_x ? {1'b0, len_q} : '0);
  assign sub_y = rem_y_q - (ge_y ? {1'b0, len_q} : '0);

  // Hold control state
  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      state_q <= DIV_IDLE;
      cnt_q   <= '0;
      done_q  <= 1'b0;
    end else begin
      state_q <= state_d;
      cnt_q   <= cnt_d;
      done_q  <= done_d;
    end
  end

  // Sequence prepare and iterations
  always_comb begin
    state_d = state_q;
    cnt_d   = cnt_q;
    done_d  = 1'b0;
    unique case (state_q)
      DIV_IDLE: begin
        if (start_i) begin
          state_d = DIV_PREP;
        end
      end
      DIV_PREP: begin
        cnt_d = '0;
        if (len == '0) begin
          state_d = DIV_IDLE;
          done_d  = 1'b1;
        end else begin
          state_d = DIV_ITER;
        end
      end
      DIV_ITER: begin
        cnt_d = cnt_q + 1'b1;
        if (cnt_q == CNT_BITS'(QUO_BITS - 1)) begin
          state_d = DIV_IDLE;
          done_d  = 1'b1;
        end
      end
      default: begin
        state_d = DIV_IDLE;
      end
    endcase
  end

  // Shift quotient bits in, remainders left
  always_ff @(posedge clk_i) begin
    unique case (state_q)
      DIV_IDLE: begin
        if (start_i) begin
          dx_q <= dx_i;
          dy_q <= dy_i;
        end
      end
      DIV_PREP: begin
        len_q     <= len;
        rem_x_q   <= {1'b0, mag_x};
        rem_y_q   <= {1'b0, mag_y};
        neg_x_q   <= dx_q[DLT_BITS-1];
        neg_y_q   <= dy_q[DLT_BITS-1];
        nonzero_q <= len != '0;
        quo_x_q   <= '0;
        quo_y_q   <= '0;
      end
      DIV_ITER: begin
        rem_x_q <= {sub_x[COORD_BITS-1:0], 1'b0};
        rem_y_q <= {sub_y[COORD_BITS-1:0], 1'b0};
        quo_x_q <= {quo_x_q[QUO_BITS-2:0], ge_x};
        quo_y_q <= {quo_y_q[QUO_BITS-2:0], ge_y};
      end
      default: begin
      end
    endcase
  end

  assign busy_o        = (state_q != DIV_IDLE) || done_q;
  assign res_o.done    = done_q;
  assign res_o.nonzero = nonzero_q;
  assign res_o.neg_x   = neg_x_q;
  assign res_o.neg_y   = neg_y_q;
  assign res_o.quo_x   = quo_x_q;
  assign res_o.quo_y   = quo_y_q;

endmodule

`default_nettype wire

// ===== design/dls_stepper.sv =====
// Position accumulator and pixel output register of the DDA line stepper.
// Truncates the position toward zero, adds the offset and detects the end of line.
// Depends on dls_pkg.
`default_nettype none

module dls_stepper (
  input  wire logic                                  clk_i,
  input  wire logic                                  rst_ni,
  input  wire logic                                  load_i,
  input  wire logic                                  step_i,
  input  wire logic signed [dls_pkg::COORD_BITS-1:0] start_x_i,
  input  wire logic signed [dls_pkg::COORD_BITS-1:0] start_y_i,
  input  wire logic signed [dls_pkg::COORD_BITS-1:0] end_x_i,
  input  wire logic signed [dls_pkg::COORD_BITS-1:0] end_y_i,
  input  wire dls_pkg::div_res_t                     div_i,
  input  wire logic signed [dls_pkg::COORD_BITS-1:0] offset_x_i,
  input  wire logic signed [dls_pkg::COORD_BITS-1:0] offset_y_i,
  input  wire logic                                  out_ready_i,
  output      logic                                  out_valid_o,
  output      logic signed [dls_pkg::OUT_BITS-1:0]   pixel_x_o,
  output      logic signed [dls_pkg::OUT_BITS-1:0]   pixel_y_o,
  output      logic                                  pixel_valid_o,
  output      logic                                  last_o
);
  import dls_pkg::*;

  logic                  active_q;
  logic                  out_valid_q;
  logic [POS_BITS-1:0]   pos_x_q, pos_y_q;
  logic [STEP_BITS-1:0]  step_x_q, step_y_q;
  logic [COORD_BITS-1:0] target_x_q, target_y_q;
  logic [OUT_BITS-1:0]   pix_x_q, pix_y_q;
  logic                  pix_vld_q, last_q;

  logic [STEP_BITS-1:0]  mag_x, mag_y;
  logic [POS_BITS-1:0]   pos_x_nx, pos_y_nx;
  logic [OUT_BITS-1:0]   fl_x, fl_y, fn_x, fn_y, tx, ty, px, py;
  logic                  near_x, near_y, at_end;

  // Current pixel: floor plus one for a negative value with a fraction
  assign fl_x = pos_x_q[POS_BITS-1:FRAC_BITS];
  assign fl_y = pos_y_q[POS_BITS-1:FRAC_BITS];
  assign px   = fl_x + OUT_BITS'(pos_x_q[POS_BITS-1] & (|pos_x_q[FRAC_BITS-1:0]))
              + {offset_x_i[COORD_BITS-1], offset_x_i};
  assign py   = fl_y + OUT_BITS'(pos_y_q[POS_BITS-1] & (|pos_y_q[FRAC_BITS-1:0]))
              + {offset_y_i[COORD_BITS-1], offset_y_i};

  // Advance the position, wrapping within its width
  assign pos_x_nx = pos_x_q + {{(POS_BITS-STEP_BITS){step_x_q[STEP_BITS-1]}}, step_x_q};
  assign pos_y_nx = pos_y_q + {{(POS_BITS-STEP_BITS){step_y_q[STEP_BITS-1]}}, step_y_q};

  // End of line: advanced position within one pixel of the target on both axes
  assign fn_x   = pos_x_nx[POS_BITS-1:FRAC_BITS];
  assign fn_y   = pos_y_nx[POS_BITS-1:FRAC_BITS];
  assign tx     = {target_x_q[COORD_BITS-1], target_x_q};
  assign ty     = {target_y_q[COORD_BITS-1], target_y_q};
  assign near_x = (fn_x == tx) || ((fn_x == tx - 1'b1) && (|pos_x_nx[FRAC_BITS-1:0]));
  assign near_y = (fn_y == ty) || ((fn_y == ty - 1'b1) && (|pos_y_nx[FRAC_BITS-1:0]));
  assign at_end = near_x && near_y;

  // Signed steps from quotient magnitudes
  assign mag_x = {1'b0, div_i.quo_x};
  assign mag_y = {1'b0, div_i.quo_y};

  // Track whether a line is being drawn
  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      active_q    <= 1'b0;
      out_valid_q <= 1'b0;
    end else begin
      if (load_i) begin
        active_q <= 1'b0;
      end else if (div_i.done) begin
        active_q <= div_i.nonzero;
      end else if (step_i && active_q && at_end) begin
        active_q <= 1'b0;
      end
      if (step_i) begin
        out_valid_q <= 1'b1;
      end else if (out_ready_i) begin
        out_valid_q <= 1'b0;
      end
    end
  end

  // Latch endpoints, steps and positions
  always_ff @(posedge clk_i) begin
    if (load_i) begin
      pos_x_q    <= {start_x_i[COORD_BITS-1], start_x_i, {FRAC_BITS{1'b0}}};
      pos_y_q    <= {start_y_i[COORD_BITS-1], start_y_i, {FRAC_BITS{1'b0}}};
      target_x_q <= end_x_i;
      target_y_q <= end_y_i;
    end else if (step_i && active_q) begin
      pos_x_q <= pos_x_nx;
      pos_y_q <= pos_y_nx;
    end
    if (div_i.done) begin
      step_x_q <= div_i.neg_x ? -mag_x : mag_x;
      step_y_q <= div_i.neg_y ? -mag_y : mag_y;
    end
  end

  // Capture the pixel word
  always_ff @(posedge clk_i) begin
    if (step_i) begin
      pix_x_q   <= active_q ? px : '0;
      pix_y_q   <= active_q ? py : '0;
      pix_vld_q <= active_q;
      last_q    <= active_q && at_end;
    end
  end

  assign out_valid_o   = out_valid_q;
  assign pixel_x_o     = pix_x_q;
  assign pixel_y_o     = pix_y_q;
  assign pixel_valid_o = pix_vld_q;
  assign last_o        = last_q;

endmodule

`default_nettype wire

// ===== design/dda_line_stepper_top.sv =====
// DDA line stepper: after a load word, the next word waits for the bit-serial
// divider, which forms one quotient bit per cycle, FRAC_BITS+1 bits in all
// (none for a zero-length line). Step words are accepted one per cycle while
// the divider is free and the output register can take a word; each pixel word
// appears in the output register in the cycle after acceptance. Reset (asynchronous,
// active low) clears the offsets, drops any line and empties the output register.
`default_nettype none

module dda_line_stepper_top (
  input  wire logic                                    clk_i,
  input  wire logic                                    rst_ni,
  input  wire logic                                    cfg_we_i,
  input  wire logic [dls_pkg::CFG_IDX_BITS-1:0]        cfg_idx_i,
  input  wire logic [dls_pkg::COORD_BITS-1:0]          cfg_data_i,
  dls_in_if.sink                                       in_i,
  dls_out_if.source                                    out_o
);
  import dls_pkg::*;

  logic signed [COORD_BITS-1:0] offset_x_q, offset_y_q;
  logic                         div_busy;
  div_res_t                     div_res;
  logic                         in_ready, in_acc, load, step;
  logic signed [DLT_BITS-1:0]   dx, dy;
  logic                         out_valid;

  // Write configuration registers
  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      offset_x_q <= '0;
      offset_y_q <= '0;
    end else if (cfg_we_i) begin
      unique case (cfg_idx_e'(cfg_idx_i))
        CFG_OFFSET_X: offset_x_q <= cfg_data_i;
        CFG_OFFSET_Y: offset_y_q <= cfg_data_i;
      endcase
    end
  end

  // Accept while the divider is free and the output register can take a word
  assign in_ready = !div_busy && (!out_valid || out_o.ready);
  assign in_acc   = in_i.valid && in_ready;
  assign load     = in_acc && (in_i.action == ACT_LOAD);
  assign step     = in_acc && (in_i.action == ACT_STEP);
  assign in_i.ready = in_ready;

  // Line deltas
  assign dx = {in_i.end_x[COORD_BITS-1], in_i.end_x}
            - {in_i.start_x[COORD_BITS-1], in_i.start_x};
  assign dy = {in_i.end_y[COORD_BITS-1], in_i.end_y}
            - {in_i.start_y[COORD_BITS-1], in_i.start_y};

  dls_divider u_div (
    .clk_i   (clk_i),
    .rst_ni  (rst_ni),
    .start_i (load),
    .dx_i    (dx),
    .dy_i    (dy),
    .busy_o  (div_busy),
    .res_o   (div_res)
  );

  dls_stepper u_step (
    .clk_i         (clk_i),
    .rst_ni        (rst_ni),
    .load_i        (load),
    .step_i        (step),
    .start_x_i     (in_i.start_x),
    .start_y_i     (in_i.start_y),
    .end_x_i       (in_i.end_x),
    .end_y_i       (in_i.end_y),
    .div_i         (div_res),
    .offset_x_i    (offset_x_q),
    .offset_y_i    (offset_y_q),
    .out_ready_i   (out_o.ready),
    .out_valid_o   (out_valid),
    .pixel_x_o     (out_o.pixel_x),
    .pixel_y_o     (out_o.pixel_y),
    .pixel_valid_o (out_o.pixel_valid),
    .last_o        (out_o.last)
  );

  assign out_o.valid = out_valid;

endmodule

`default_nettype wire

// ===== design/dls_checker.sv =====
// Port-level checks for the DDA line stepper, bound to the top level.
// Depends on dls_pkg and dda_line_stepper_top.
`default_nettype none

module dls_checker (
  input wire logic                                clk_i,
  input wire logic                                rst_ni,
  input wire logic                                in_valid_i,
  input wire logic                                in_ready_i,
  input wire logic                                in_action_i,
  input wire logic                                out_valid_i,
  input wire logic                                out_ready_i,
  input wire logic signed [dls_pkg::OUT_BITS-1:0] pixel_x_i,
  input wire logic signed [dls_pkg::OUT_BITS-1:0] pixel_y_i,
  input wire logic                                pixel_valid_i,
  input wire logic                                last_i
);
  import dls_pkg::*;

  // Hold a word until it is taken
  a_out_hold: assert property (@(posedge clk_i) disable iff (!rst_ni)
    out_valid_i && !out_ready_i |=> out_valid_i)
    else $error("pixel word dropped while stalled");

  // A word without a pixel carries zero fields
  a_idle_zero: assert property (@(posedge clk_i) disable iff (!rst_ni)
    out_valid_i && !pixel_valid_i |-> (pixel_x_i == '0) && (pixel_y_i == '0) && !last_i)
    else $error("word without pixel has nonzero fields");

  // Only a drawn pixel closes a line
  a_last_pix: assert property (@(posedge clk_i) disable iff (!rst_ni)
    out_valid_i && last_i |-> pixel_valid_i)
    else $error("last flagged on a word without pixel");

  // A load occupies the divider in the following cycle
  a_load_busy: assert property (@(posedge clk_i) disable iff (!rst_ni)
    in_valid_i && in_ready_i && (in_action_i == ACT_LOAD) |=> !in_ready_i)
    else $error("word accepted while the step division runs");

endmodule

bind dda_line_stepper_top dls_checker u_dls_checker (
  .clk_i         (clk_i),
  .rst_ni        (rst_ni),
  .in_valid_i    (in_i.valid),
  .in_ready_i    (in_i.ready),
  .in_action_i   (in_i.action),
  .out_valid_i   (out_o.valid),
  .out_ready_i   (out_o.ready),
  .pixel_x_i     (out_o.pixel_x),
  .pixel_y_i     (out_o.pixel_y),
  .pixel_valid_i (out_o.pixel_valid),
  .last_i        (out_o.last)
);

`default_nettype wire

// ===== tb/sv/tb_dda_line_stepper_top.sv =====
// Self-checking testbench for dda_line_stepper_top: drives line load and step words,
// predicts each pixel word in a scoreboard class and checks the pixel channel.
// Depends on dls_pkg, dls_in_if, dls_out_if and the design top.
`timescale 1ns / 1ps

module tb_dda_line_stepper_top;
  import dls_pkg::*;

  localparam int CLK_HALF_NS  = 4;
  localparam int RESET_CYCLES = 3;
  localparam int DRAIN_CYCLES = 40;   // margin for a pending load divide
  localparam int HOLD_CYCLES  = 200;  // long receiver hold-off
  localparam int TIMEOUT_NS   = 2_000_000;
  localparam int PHASE_WORDS  = 150;

  typedef struct {
    action_e                      action;
    logic signed [COORD_BITS-1:0] start_x;
    logic signed [COORD_BITS-1:0] start_y;
    logic signed [COORD_BITS-1:0] end_x;
    logic signed [COORD_BITS-1:0] end_y;
  } line_word_t;

  typedef struct {
    logic signed [OUT_BITS-1:0] pixel_x;
    logic signed [OUT_BITS-1:0] pixel_y;
    logic                       pixel_valid;
    logic                       last;
  } pixel_word_t;

  // Line state mirror and queue of pixel words still owed by the block
  class pixel_predictor;
    logic signed [COORD_BITS-1:0] offset_x;
    logic signed [COORD_BITS-1:0] offset_y;
    logic signed [POS_BITS-1:0]   pos_x;
    logic signed [POS_BITS-1:0]   pos_y;
    logic signed [STEP_BITS-1:0]  step_x;
    logic signed [STEP_BITS-1:0]  step_y;
    logic signed [COORD_BITS-1:0] tgt_x;
    logic signed [COORD_BITS-1:0] tgt_y;
    logic                         line_on;
    pixel_word_t                  pixels_due[$];
    int                           mismatches;

    function new();
      offset_x   = '0;
      offset_y   = '0;
      pos_x      = '0;
      pos_y      = '0;
      step_x     = '0;
      step_y     = '0;
      tgt_x      = '0;
      tgt_y      = '0;
      line_on    = 1'b0;
      mismatches = 0;
    endfunction

    function int pending();
      return pixels_due.size();
    endfunction

    function void write_reg(cfg_idx_e idx, logic [COORD_BITS-1:0] val);
      if (idx == CFG_OFFSET_X) offset_x = val;
      else offset_y = val;
    endfunction

    // Fixed-point step: |d| * 2^FRAC / len, truncated, sign restored
    function logic signed [STEP_BITS-1:0] axis_step(longint d, longint len);
      longint q;
      q = ((d < 0 ? -d : d) <<< FRAC_BITS) / len;
      return STEP_BITS'(d < 0 ? -q : q);
    endfunction

    // Both truncated distances to the end point are zero
    function bit reaches_end();
      longint one;
      longint ex;
      longint ey;
      one = longint'(1) <<< FRAC_BITS;
      ex  = longint'(pos_x) - longint'(tgt_x) * one;
      ey  = longint'(pos_y) - longint'(tgt_y) * one;
      return (ex < one && -ex < one && ey < one && -ey < one);
    endfunction

    // Integer part, truncated toward zero
    function longint pos_int(logic signed [POS_BITS-1:0] p);
      return longint'(p) / (longint'(1) <<< FRAC_BITS);
    endfunction

    function void note_word(line_word_t w);
      longint      dx;
      longint      dy;
      longint      len;
      pixel_word_t px;
      if (w.action == ACT_LOAD) begin
        dx    = longint'(w.end_x) - longint'(w.start_x);
        dy    = longint'(w.end_y) - longint'(w.start_y);
        len   = (dx < 0 ? -dx : dx);
        if ((dy < 0 ? -dy : dy) > len) len = (dy < 0 ? -dy : dy);
        tgt_x = w.end_x;
        tgt_y = w.end_y;
        pos_x = POS_BITS'(longint'(w.start_x) <<< FRAC_BITS);
        pos_y = POS_BITS'(longint'(w.start_y) <<< FRAC_BITS);
        if (len == 0) begin
          step_x  = '0;
          step_y  = '0;
          line_on = 1'b0;
        end else begin
          step_x  = axis_step(dx, len);
          step_y  = axis_step(dy, len);
          line_on = !reaches_end();
        end
        return;
      end
      // Step with no line: an empty pixel word, state unchanged
      if (!line_on) begin
        px = '{default: '0};
        pixels_due.push_back(px);
        return;
      end
      px.pixel_x     = OUT_BITS'(longint'(offset_x) + pos_int(pos_x));
      px.pixel_y     = OUT_BITS'(longint'(offset_y) + pos_int(pos_y));
      px.pixel_valid = 1'b1;
      pos_x          = pos_x + step_x;
      pos_y          = pos_y + step_y;
      px.last        = reaches_end();
      if (px.last) line_on = 1'b0;
      pixels_due.push_back(px);
    endfunction

    function void report(string field, int exp_v, int got_v);
      $display("%0t ns: mismatch on %s: expected %0d, actual %0d",
               $time, field, exp_v, got_v);
      mismatches++;
    endfunction

    function void check_pixel(pixel_word_t got);
      pixel_word_t exp_w;
      if (pixels_due.size() == 0) begin
        $display("%0t ns: unexpected pixel word x=%0d y=%0d valid=%0b last=%0b",
                 $time, got.pixel_x, got.pixel_y, got.pixel_valid, got.last);
        mismatches++;
        return;
      end
      exp_w = pixels_due.pop_front();
      if (got.pixel_x !== exp_w.pixel_x) report("pixel_x", exp_w.pixel_x, got.pixel_x);
      if (got.pixel_y !== exp_w.pixel_y) report("pixel_y", exp_w.pixel_y, got.pixel_y);
      if (got.pixel_valid !== exp_w.pixel_valid)
        report("pixel_valid", exp_w.pixel_valid, got.pixel_valid);
      if (got.last !== exp_w.last) report("last", exp_w.last, got.last);
    endfunction
  endclass

  logic                  clk_i;
  logic                  rst_ni;
  logic                  cfg_we_i;
  logic [CFG_IDX_BITS-1:0] cfg_idx_i;
  logic [COORD_BITS-1:0] cfg_data_i;

  dls_in_if  in_if ();
  dls_out_if out_if ();

  dda_line_stepper_top u_top (
    .clk_i      (clk_i),
    .rst_ni     (rst_ni),
    .cfg_we_i   (cfg_we_i),
    .cfg_idx_i  (cfg_idx_i),
    .cfg_data_i (cfg_data_i),
    .in_i       (in_if),
    .out_o      (out_if)
  );

  pixel_predictor sb;
  int             words_sent;
  bit             steady;    // no gaps on either side
  bit             hold_req;  // ask the receiver for one long hold-off

  // Clock
  initial begin
    clk_i = 1'b0;
    forever #(CLK_HALF_NS) clk_i = ~clk_i;
  end

  // Run limit
  initial begin
    #(TIMEOUT_NS);
    $display("Some tests failed");
    $finish;
  end

  // Note accepted line words, then check accepted pixel words
  always @(posedge clk_i) begin : monitor
    line_word_t  w;
    pixel_word_t p;
    if (rst_ni) begin
      if (in_if.valid && in_if.ready) begin
        w.action  = action_e'(in_if.action);
        w.start_x = in_if.start_x;
        w.start_y = in_if.start_y;
        w.end_x   = in_if.end_x;
        w.end_y   = in_if.end_y;
        sb.note_word(w);
      end
      if (out_if.valid && out_if.ready) begin
        p.pixel_x     = out_if.pixel_x;
        p.pixel_y     = out_if.pixel_y;
        p.pixel_valid = out_if.pixel_valid;
        p.last        = out_if.last;
        sb.check_pixel(p);
      end
    end
  end

  // Pixel receiver: random ready, mostly short stalls, a few long ones
  initial begin : receiver
    int r;
    int n;
    out_if.ready <= 1'b0;
    @(posedge clk_i);
    forever begin
      if (hold_req) begin
        hold_req = 1'b0;
        out_if.ready <= 1'b0;
        repeat (HOLD_CYCLES) @(posedge clk_i);
      end else begin
        r = $urandom_range(0, 99);
        if (steady || r < 60) begin
          out_if.ready <= 1'b1;
          n = $urandom_range(1, 20);
        end else if (r < 95) begin
          out_if.ready <= 1'b0;
          n = $urandom_range(1, 3);
        end else begin
          out_if.ready <= 1'b0;
          n = $urandom_range(20, 60);
        end
        repeat (n) @(posedge clk_i);
      end
    end
  end

  // Offer one word after a random gap and hold it until accepted
  task automatic send_word(line_word_t w);
    int r;
    int gap;
    r   = $urandom_range(0, 99);
    gap = 0;
    if (!steady) begin
      if (r >= 92) gap = $urandom_range(8, 40);
      else if (r >= 55) gap = $urandom_range(1, 3);
    end
    if (gap > 0) begin
      in_if.valid <= 1'b0;
      repeat (gap) @(posedge clk_i);
    end
    in_if.valid   <= 1'b1;
    in_if.action  <= w.action;
    in_if.start_x <= w.start_x;
    in_if.start_y <= w.start_y;
    in_if.end_x   <= w.end_x;
    in_if.end_y   <= w.end_y;
    @(posedge clk_i);
    while (!in_if.ready) @(posedge clk_i);
    words_sent++;
  endtask

  task automatic load_line(int sx, int sy, int ex, int ey);
    line_word_t w;
    w.action  = ACT_LOAD;
    w.start_x = COORD_BITS'(sx);
    w.start_y = COORD_BITS'(sy);
    w.end_x   = COORD_BITS'(ex);
    w.end_y   = COORD_BITS'(ey);
    send_word(w);
  endtask

  // Step words carry random, ignored coordinates
  task automatic step_line(int n);
    line_word_t w;
    for (int i = 0; i < n; i++) begin
      w.action  = ACT_STEP;
      w.start_x = COORD_BITS'($urandom);
      w.start_y = COORD_BITS'($urandom);
      w.end_x   = COORD_BITS'($urandom);
      w.end_y   = COORD_BITS'($urandom);
      send_word(w);
    end
  endtask

  // Drop valid, let the monitor note the last word, wait for every owed
  // pixel, then let a pending divide finish
  task automatic wait_idle();
    in_if.valid <= 1'b0;
    @(posedge clk_i);
    while (sb.pending() != 0) @(posedge clk_i);
    repeat (DRAIN_CYCLES) @(posedge clk_i);
  endtask

  // Write both offsets on back-to-back edges while idle
  task automatic set_offsets(int ox, int oy);
    wait_idle();
    cfg_we_i   <= 1'b1;
    cfg_idx_i  <= CFG_OFFSET_X;
    cfg_data_i <= COORD_BITS'(ox);
    @(posedge clk_i);
    sb.write_reg(CFG_OFFSET_X, COORD_BITS'(ox));
    cfg_idx_i  <= CFG_OFFSET_Y;
    cfg_data_i <= COORD_BITS'(oy);
    @(posedge clk_i);
    sb.write_reg(CFG_OFFSET_Y, COORD_BITS'(oy));
    cfg_we_i   <= 1'b0;
  endtask

  function automatic int clamp_coord(int v);
    if (v > 2047) return 2047;
    if (v < -2048) return -2048;
    return v;
  endfunction

  function automatic int abs_int(int v);
    return v < 0 ? -v : v;
  endfunction

  // One load followed by a run of steps: mostly the full line, sometimes
  // cut short by the next load or run past the end
  task automatic random_line();
    int r;
    int sx;
    int sy;
    int ex;
    int ey;
    int span;
    int len;
    int n;
    r  = $urandom_range(0, 99);
    sx = int'($urandom_range(0, 4095)) - 2048;
    sy = int'($urandom_range(0, 4095)) - 2048;
    if (r < 8) begin
      ex = sx;
      ey = sy;
    end else if (r < 18) begin
      ex = int'($urandom_range(0, 4095)) - 2048;
      ey = int'($urandom_range(0, 4095)) - 2048;
    end else begin
      span = (r < 35) ? 40 : 12;
      ex   = clamp_coord(sx + int'($urandom_range(0, 2 * span)) - span);
      ey   = clamp_coord(sy + int'($urandom_range(0, 2 * span)) - span);
    end
    len = abs_int(ex - sx);
    if (abs_int(ey - sy) > len) len = abs_int(ey - sy);
    load_line(sx, sy, ex, ey);
    r = $urandom_range(0, 99);
    if (len > 60) n = $urandom_range(1, 12);
    else if (r < 70) n = len;
    else if (r < 85) n = len + $urandom_range(1, 3);
    else n = $urandom_range(0, len);
    step_line(n);
  endtask

  task automatic random_phase(int count);
    int first;
    first = words_sent;
    while (words_sent - first < count) random_line();
  endtask

  // Main sequence
  initial begin : stimulus
    sb         = new();
    words_sent = 0;
    steady     = 1'b0;
    hold_req   = 1'b0;
    rst_ni     <= 1'b0;
    cfg_we_i   <= 1'b0;
    cfg_idx_i  <= CFG_OFFSET_X;
    cfg_data_i <= '0;
    in_if.valid   <= 1'b0;
    in_if.action  <= ACT_LOAD;
    in_if.start_x <= '0;
    in_if.start_y <= '0;
    in_if.end_x   <= '0;
    in_if.end_y   <= '0;
    repeat (RESET_CYCLES) @(posedge clk_i);
    rst_ni <= 1'b1;
    @(posedge clk_i);

    // Directed: step with no line, zero-length line, short line run past
    // its end, extreme diagonals replaced mid-line, steep negative line,
    // single-pixel line
    step_line(1);
    set_offsets(3, -5);
    load_line(5, 5, 5, 5);
    step_line(1);
    load_line(0, 0, 3, 1);
    step_line(4);
    load_line(-2048, -2048, 2047, 2047);
    step_line(3);
    load_line(2047, -2048, -2048, 2047);
    step_line(2);
    load_line(0, 0, -1, -5);
    step_line(6);
    load_line(10, 10, 11, 10);
    step_line(1);

    // Random phases over several offset settings
    set_offsets(2047, -2048);
    random_phase(PHASE_WORDS);

    // Hold the receiver off while step words are offered back to back
    set_offsets(-2048, 2047);
    hold_req = 1'b1;
    steady   = 1'b1;
    load_line(0, 0, 50, -20);
    step_line(50);
    steady   = 1'b0;
    random_phase(PHASE_WORDS);

    set_offsets(0, 0);
    steady = 1'b1;
    random_phase(PHASE_WORDS / 2);
    steady = 1'b0;
    random_phase(PHASE_WORDS / 2);

    set_offsets(int'($urandom_range(0, 4095)) - 2048, int'($urandom_range(0, 4095)) - 2048);
    random_phase(PHASE_WORDS);

    wait_idle();
    if (sb.mismatches == 0 && sb.pending() == 0) begin
      $display("All tests passed");
    end else begin
      $display("Some tests failed");
    end
    $finish;
  end

endmodule

// ===== filelist.f =====
design/dls_pkg.sv
design/dls_if.sv
design/dls_divider.sv
design/dls_stepper.sv
design/dda_line_stepper_top.sv
design/dls_checker.sv
tb/sv/tb_dda_line_stepper_top.sv
